// ===== src/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Record layout, table sizing, request and status codes, cell control bundle.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Table sizing
  localparam int TABLE_DEPTH  = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

  // Field widths
  localparam int REQ_W   = 3;
  localparam int ST_W    = 3;
  localparam int KEY_W   = 15;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 15;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((KEY_W + 2 * PRICE_W + QTY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((KEY_W + PRICE_W + QTY_W + 7) / 8) * 8;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_RANGE  = 3'd4,
    REQ_LIST   = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_RANGE = 3'd5
  } status_e;

  // One table record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } record_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             rotate;   // every cell takes its right neighbour's record
    logic             compact;  // cells at or above pos take their neighbour's record
    logic [IDX_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== src/krt_cell.sv =====
// ----------------------------------------------------------------------------
// krt_cell: one storage cell of the record chain
// Holds a single record and loads its right neighbour's record on a rotate
// step, or on a compaction step when it sits at or above the removed slot.
// ----------------------------------------------------------------------------
module krt_cell (
  input  logic                    clk_i,
  input  krt_pkg::cell_ctl_t      ctl_i,
  input  logic [krt_pkg::IDX_W-1:0] idx_i,
  input  krt_pkg::record_t        rec_i,
  output krt_pkg::record_t        rec_o
);

  krt_pkg::record_t rec_q;
  logic             load;

  // Load decision: full rotation, or shift-down above the deleted slot
  assign load = ctl_i.rotate | (ctl_i.compact & (idx_i >= ctl_i.pos));

  // Record storage, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== src/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl: request sequencer for the keyed record table
// Takes one request, rotates the cell chain once round past the head cell,
// decides the results on the fly and drives the output register.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [krt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [krt_pkg::REQ_W-1:0]      s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [krt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [krt_pkg::ST_W-1:0]       m_axis_tuser,
  output logic                           m_axis_tlast,
  // cell chain
  input  krt_pkg::record_t               head_i,
  output krt_pkg::record_t               inject_o,
  output krt_pkg::cell_ctl_t             ctl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_CMPCT
  } state_e;

  localparam int KEY_LO = 0;
  localparam int LO_LO  = KEY_LO + krt_pkg::KEY_W;
  localparam int HI_LO  = LO_LO + krt_pkg::PRICE_W;
  localparam int QTY_LO = HI_LO + krt_pkg::PRICE_W;

  state_e                          state_q;
  krt_pkg::req_e                   req_q;
  logic [krt_pkg::KEY_W-1:0]       key_q;
  logic [krt_pkg::PRICE_W-1:0]     lo_q;
  logic [krt_pkg::PRICE_W-1:0]     hi_q;
  logic [krt_pkg::QTY_W-1:0]       qty_q;
  logic [krt_pkg::CNT_W-1:0]       count_q;
  logic [krt_pkg::IDX_W-1:0]       step_q;
  logic [krt_pkg::IDX_W-1:0]       pos_q;
  logic [krt_pkg::RES_W-1:0]       nres_q;
  logic                            found_q;
  logic                            bad_q;
  logic                            pend_vld_q;
  krt_pkg::record_t                pend_q;
  logic                            out_vld_q;
  krt_pkg::record_t                out_rec_q;
  krt_pkg::status_e                out_st_q;
  logic                            out_last_q;

  krt_pkg::req_e                   in_req;
  logic                            in_known;
  logic                            accept;
  logic                            emit_ok;
  logic                            live;
  logic                            key_hit;
  logic                            first_hit;
  logic                            in_rng;
  logic                            sel_req;
  logic                            sel_hit;
  logic                            stall;
  logic                            rotate;
  logic                            scan_emit;
  logic                            fin_go;
  logic                            load_out;
  logic                            last_step;
  krt_pkg::record_t                new_rec;
  krt_pkg::record_t                inject;
  krt_pkg::record_t                fin_rec;
  krt_pkg::status_e                fin_st;
  logic [krt_pkg::CNT_W-1:0]       count_d;
  state_e                          fin_next;

  // Input decode
  assign in_req   = krt_pkg::req_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid & s_axis_tready;

  always_comb begin
    unique case (in_req)
      krt_pkg::REQ_INSERT, krt_pkg::REQ_LOOKUP, krt_pkg::REQ_UPDATE,
      krt_pkg::REQ_DELETE, krt_pkg::REQ_RANGE, krt_pkg::REQ_LIST: in_known = 1'b1;
      default:                                                   in_known = 1'b0;
    endcase
  end

  // Output slot free this cycle
  assign emit_ok = ~out_vld_q | m_axis_tready;

  // Head cell examination
  assign live      = (krt_pkg::CNT_W'(step_q) < count_q);
  assign key_hit   = live && (head_i.key == key_q);
  assign first_hit = key_hit && !found_q;
  assign in_rng    = (head_i.price >= lo_q) && (head_i.price <= hi_q);
  assign sel_req   = (req_q == krt_pkg::REQ_RANGE) || (req_q == krt_pkg::REQ_LIST);
  assign sel_hit   = sel_req && live && !bad_q &&
                     (nres_q < krt_pkg::RES_W'(krt_pkg::RESULT_LIMIT)) &&
                     ((req_q == krt_pkg::REQ_LIST) || in_rng);
  assign scan_emit = (state_q == S_SCAN) && sel_hit && pend_vld_q;
  assign stall     = scan_emit && !emit_ok;
  assign rotate    = (state_q == S_SCAN) && !stall;
  assign last_step = (step_q == krt_pkg::IDX_W'(krt_pkg::TABLE_DEPTH - 1));
  assign fin_go    = (state_q == S_FIN) && emit_ok;
  assign load_out  = (scan_emit && emit_ok) || fin_go;

  assign new_rec = '{key: key_q, price: lo_q, qty: qty_q};

  // Record fed back into the tail of the chain
  always_comb begin
    inject = head_i;
    if (state_q == S_SCAN) begin
      if ((req_q == krt_pkg::REQ_INSERT) && !found_q &&
          (krt_pkg::CNT_W'(step_q) == count_q)) begin
        inject = new_rec;
      end else if ((req_q == krt_pkg::REQ_UPDATE) && first_hit) begin
        inject.qty = qty_q;
      end
    end
  end

  assign inject_o    = inject;
  assign ctl_o.rotate  = rotate;
  assign ctl_o.compact = (state_q == S_CMPCT);
  assign ctl_o.pos     = pos_q;

  // Final result of a request
  always_comb begin
    fin_st   = krt_pkg::ST_NOT_FOUND;
    fin_rec  = '0;
    fin_next = S_IDLE;
    count_d  = count_q;
    unique case (req_q)
      krt_pkg::REQ_INSERT: begin
        if (found_q) begin
          fin_st = krt_pkg::ST_DUPLICATE;
        end else if (count_q == krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)) begin
          fin_st = krt_pkg::ST_FULL;
        end else begin
          fin_st  = krt_pkg::ST_OK;
          fin_rec = new_rec;
          count_d = count_q + krt_pkg::CNT_W'(1);
        end
      end
      krt_pkg::REQ_LOOKUP, krt_pkg::REQ_UPDATE: begin
        if (found_q) begin
          fin_st  = krt_pkg::ST_OK;
          fin_rec = pend_q;
        end
      end
      krt_pkg::REQ_DELETE: begin
        if (count_q == '0) begin
          fin_st = krt_pkg::ST_EMPTY;
        end else if (found_q) begin
          fin_st   = krt_pkg::ST_OK;
          fin_rec  = pend_q;
          fin_next = S_CMPCT;
          count_d  = count_q - krt_pkg::CNT_W'(1);
        end
      end
      krt_pkg::REQ_RANGE: begin
        if (bad_q) begin
          fin_st = krt_pkg::ST_BAD_RANGE;
        end else if (pend_vld_q) begin
          fin_st  = krt_pkg::ST_OK;
          fin_rec = pend_q;
        end
      end
      krt_pkg::REQ_LIST: begin
        if (pend_vld_q) begin
          fin_st  = krt_pkg::ST_OK;
          fin_rec = pend_q;
        end else begin
          fin_st = krt_pkg::ST_EMPTY;
        end
      end
      default: begin
        fin_st = krt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Sequencer state and registered output flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      step_q     <= '0;
      nres_q     <= '0;
      found_q    <= 1'b0;
      bad_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q  <= 1'b1;
        out_last_q <= fin_go;
      end else if (m_axis_tready) begin
        out_vld_q  <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && in_known) begin
            state_q    <= S_SCAN;
            step_q     <= '0;
            nres_q     <= '0;
            found_q    <= 1'b0;
            pend_vld_q <= 1'b0;
            bad_q      <= (in_req == krt_pkg::REQ_RANGE) &&
                          (s_axis_tdata[LO_LO +: krt_pkg::PRICE_W] >=
                           s_axis_tdata[HI_LO +: krt_pkg::PRICE_W]);
          end
        end
        S_SCAN: begin
          if (rotate) begin
            // a key match marks the request found, duplicates for an insert
            if (!sel_req && first_hit) begin
              found_q <= 1'b1;
            end
            if (sel_hit) begin
              pend_vld_q <= 1'b1;
              nres_q     <= nres_q + krt_pkg::RES_W'(1);
            end
            if (last_step) begin
              state_q <= S_FIN;
            end else begin
              step_q <= step_q + krt_pkg::IDX_W'(1);
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_q <= fin_next;
            count_q <= count_d;
          end
        end
        S_CMPCT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields, pending record and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req;
      key_q <= s_axis_tdata[KEY_LO +: krt_pkg::KEY_W];
      lo_q  <= s_axis_tdata[LO_LO +: krt_pkg::PRICE_W];
      hi_q  <= s_axis_tdata[HI_LO +: krt_pkg::PRICE_W];
      qty_q <= s_axis_tdata[QTY_LO +: krt_pkg::QTY_W];
    end
    if (rotate) begin
      if (!sel_req && first_hit) begin
        pend_q <= inject;
        pos_q  <= step_q;
      end else if (sel_hit) begin
        pend_q <= head_i;
      end
    end
    if (fin_go) begin
      out_rec_q <= fin_rec;
      out_st_q  <= fin_st;
    end else if (load_out) begin
      out_rec_q <= pend_q;
      out_st_q  <= krt_pkg::ST_OK;
    end
  end

  // Result stream
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = krt_pkg::OUT_DATA_W'({out_rec_q.qty, out_rec_q.price, out_rec_q.key});

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_cmpct_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMPCT) |-> ($past(state_q) == S_FIN))
    else $error("compaction not preceded by final step");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_FIN))
    else $error("entry count changed outside final step");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= krt_pkg::RES_W'(krt_pkg::RESULT_LIMIT))
    else $error("result count beyond limit");

  a_last_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (state_q == S_SCAN)) |=> (out_vld_q && !out_last_q))
    else $error("mid-scan result flagged as last");

endmodule

// ===== src/keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table: compacted keyed record table on a rotating cell chain
// Insert, lookup, quantity update, delete, price range query and list all.
// ----------------------------------------------------------------------------
// A request is accepted while idle, the chain rotates once round past its head
//   cell in the scan state, and the final state issues the last result; a delete
//   then passes through a compaction state before the next request is taken.
// A new request is taken only after the previous one has finished its single pass
//   of the chain past the head cell; scan and final steps stall on back-pressure.
// Reset: entry count cleared and sequencer idle; record cells hold no reset.
module keyed_record_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_id[14:0], item_price[38:15], range_max[62:39], item_quantity[77:63]
  input  logic [krt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [krt_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found_id[14:0], found_price[38:15], found_quantity[53:39]
  output logic [krt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [krt_pkg::ST_W-1:0]       m_axis_tuser,
  output logic                           m_axis_tlast
);

  krt_pkg::record_t   cell_rec [krt_pkg::TABLE_DEPTH];
  krt_pkg::record_t   inject;
  krt_pkg::cell_ctl_t cell_ctl;

  // Sequencer
  krt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .head_i        (cell_rec[0]),
    .inject_o      (inject),
    .ctl_o         (cell_ctl)
  );

  // Cell chain: each cell takes its right neighbour, the tail takes the feed-back
  for (genvar i = 0; i < krt_pkg::TABLE_DEPTH; i++) begin : g_cell
    krt_pkg::record_t nxt;
    if (i == krt_pkg::TABLE_DEPTH - 1) begin : g_tail
      assign nxt = inject;
    end else begin : g_body
      assign nxt = cell_rec[i+1];
    end
    krt_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (cell_ctl),
      .idx_i (krt_pkg::IDX_W'(i)),
      .rec_i (nxt),
      .rec_o (cell_rec[i])
    );
  end

endmodule
